### rtl/event_time_priority_queue_macros.svh
// assertion macros for the event time priority queue checker
// used by etpq_checker.sv, needs a signal named clock and one named reset in scope
`ifndef EVENT_TIME_PRIORITY_QUEUE_MACROS_SVH
`define EVENT_TIME_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define ETPQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet while reset is high
`define ETPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/etpq_pkg.sv
// shared types and constants of the event time priority queue
// no dependencies; used by every module of the block but etpq_ram
package etpq_pkg;

   localparam int KEY_BITS             = 32;
   localparam int IN_PAYLOAD_BITS      = 16;
   localparam int OCC_BITS             = 7;
   localparam int DEPTH_DEFAULT        = 64;
   localparam int PAYLOAD_BITS_DEFAULT = 16;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_POP    = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      op_type                     op;
      logic [KEY_BITS-1:0]        key;
      logic [IN_PAYLOAD_BITS-1:0] payload;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic [KEY_BITS-1:0]        out_key;
      logic [IN_PAYLOAD_BITS-1:0] out_payload;
      logic [OCC_BITS-1:0]        occupancy;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       rd_last;
      logic       rd_head;
      logic       shift;
      logic       put_new;
      logic       take_head;
      logic       respond;
      status_type rsp_status;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_pop;
      logic empty;
      logic full;
      logic key_greater;
      logic last_one;
   } dp_stat_type;

endpackage

### rtl/etpq_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module etpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/etpq_ctrl.sv
// sequencing state machine of the event time priority queue
// depends on etpq_pkg
module etpq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  etpq_pkg::dp_stat_type stat,
   output etpq_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CHECK = 5'b00010,
      S_POP   = 5'b00100,
      S_SCAN  = 5'b01000,
      S_PUT   = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.rsp_status = etpq_pkg::ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.is_pop) begin
               if (stat.empty) begin
                  cmd.respond    = 1'b1;
                  cmd.rsp_status = etpq_pkg::ST_EMPTY;
                  state_in       = S_IDLE;
               end else begin
                  cmd.rd_head = 1'b1;
                  state_in    = S_POP;
               end
            end else if (stat.full) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = etpq_pkg::ST_FULL;
               state_in       = S_IDLE;
            end else if (stat.empty) begin
               cmd.put_new = 1'b1;
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.rd_last = 1'b1;
               state_in    = S_SCAN;
            end
         end
         S_POP: begin
            cmd.take_head = 1'b1;
            cmd.respond   = 1'b1;
            state_in      = S_IDLE;
         end
         S_SCAN: begin
            // walk from the tail toward the head, moving later keys up one slot
            if (stat.key_greater) begin
               cmd.shift = 1'b1;
               if (stat.last_one) begin
                  state_in = S_PUT;
               end
            end else begin
               cmd.put_new = 1'b1;
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_PUT: begin
            cmd.put_new = 1'b1;
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

### rtl/etpq_datapath.sv
// pointers, count, entry ram and result register of the event time priority queue
// depends on etpq_pkg and etpq_ram
module etpq_datapath #(
   parameter int DEPTH        = etpq_pkg::DEPTH_DEFAULT,
   parameter int PAYLOAD_BITS = etpq_pkg::PAYLOAD_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  etpq_pkg::req_type      req_data,
   input  etpq_pkg::ctrl_cmd_type cmd,
   output etpq_pkg::dp_stat_type  stat,
   output logic                   rsp_valid,
   output etpq_pkg::rsp_type      rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int KW = etpq_pkg::KEY_BITS;
   localparam int EW = KW + PAYLOAD_BITS;

   etpq_pkg::req_type req_ff, req_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [AW-1:0]     tail_ff, tail_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]     remain_ff, remain_in;
   logic              rsp_valid_ff, rsp_valid_in;
   etpq_pkg::rsp_type rsp_ff, rsp_in;

   logic [AW-1:0]           last_slot;
   logic [AW-1:0]           prev_rd;
   logic [AW-1:0]           ram_rd_addr;
   logic                    ram_wr_en;
   logic [EW-1:0]           ram_wr_data;
   logic [EW-1:0]           ram_rd_data;
   logic [KW-1:0]           rd_key;
   logic [PAYLOAD_BITS-1:0] rd_payload;

   // circular slot arithmetic, depth need not be a power of two
   function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] p);
      return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
   endfunction

   assign last_slot  = slot_prev(tail_ff);
   assign prev_rd    = slot_prev(rd_ptr_ff);
   assign rd_key     = ram_rd_data[EW-1 -: KW];
   assign rd_payload = ram_rd_data[PAYLOAD_BITS-1:0];

   always_comb begin
      if (cmd.rd_last) begin
         ram_rd_addr = last_slot;
      end else if (cmd.rd_head) begin
         ram_rd_addr = head_ff;
      end else begin
         ram_rd_addr = prev_rd;
      end
   end

   assign ram_wr_en   = cmd.shift | cmd.put_new;
   assign ram_wr_data = cmd.shift ? ram_rd_data
                                  : {req_ff.key, PAYLOAD_BITS'(req_ff.payload)};

   etpq_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      req_in       = req_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      remain_in    = remain_ff;
      rsp_valid_in = cmd.respond;
      rsp_in       = rsp_ff;

      if (cmd.load_req) begin
         req_in    = req_data;
         // empty queue: new word goes straight to the tail slot
         wr_ptr_in = tail_ff;
      end
      if (cmd.rd_last) begin
         rd_ptr_in = last_slot;
         wr_ptr_in = tail_ff;
         remain_in = count_ff;
      end
      if (cmd.shift) begin
         wr_ptr_in = rd_ptr_ff;
         rd_ptr_in = prev_rd;
         remain_in = remain_ff - CW'(1);
      end
      if (cmd.put_new) begin
         tail_in  = slot_next(tail_ff);
         count_in = count_ff + CW'(1);
      end
      if (cmd.take_head) begin
         head_in  = slot_next(head_ff);
         count_in = count_ff - CW'(1);
      end
      if (cmd.respond) begin
         rsp_in.status      = cmd.rsp_status;
         rsp_in.out_key     = cmd.take_head ? rd_key : '0;
         rsp_in.out_payload = cmd.take_head ? etpq_pkg::IN_PAYLOAD_BITS'(rd_payload) : '0;
         rsp_in.occupancy   = etpq_pkg::OCC_BITS'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         wr_ptr_ff    <= '0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_ptr_ff    <= wr_ptr_in;
      end
      req_ff    <= req_in;
      rd_ptr_ff <= rd_ptr_in;
      remain_ff <= remain_in;
      rsp_ff    <= rsp_in;
   end

   assign stat.is_pop      = (req_ff.op == etpq_pkg::OP_POP);
   assign stat.empty       = (count_ff == '0);
   assign stat.full        = (count_ff == CW'(DEPTH));
   assign stat.key_greater = (rd_key > req_ff.key);
   assign stat.last_one    = (remain_ff == CW'(1));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/event_time_priority_queue.sv
// Event queue kept sorted by time key, ties leaving in arrival order. Entries
// sit in one ram as a ring between a head and a tail pointer, so a pop reads
// the head word. An insert into a non-empty queue walks back from the tail,
// moving each later key up one slot per cycle through the single ram write
// port, then writes the new key into the slot left free; at most every stored
// key moves. A pop on an empty queue, an insert into an empty queue or an
// insert into a full one is answered from the check state. Each result word
// shows for one cycle under rsp_valid and cannot be held off; busy is low
// whenever a new word may be started. No clearing pass follows reset.
// depends on etpq_pkg, etpq_ctrl, etpq_datapath
module event_time_priority_queue #(
   parameter int DEPTH        = etpq_pkg::DEPTH_DEFAULT,
   parameter int PAYLOAD_BITS = etpq_pkg::PAYLOAD_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  etpq_pkg::req_type req_data,
   output logic              rsp_valid,
   output etpq_pkg::rsp_type rsp_data
);

   etpq_pkg::ctrl_cmd_type cmd;
   etpq_pkg::dp_stat_type  stat;

   etpq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   etpq_datapath #(
      .DEPTH        (DEPTH),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/etpq_checker.sv
// port-level checks of the event time priority queue, bound to the top level
// depends on etpq_pkg and event_time_priority_queue_macros.svh
`include "event_time_priority_queue_macros.svh"

module etpq_checker #(
   parameter int DEPTH = etpq_pkg::DEPTH_DEFAULT
) (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input etpq_pkg::rsp_type rsp_data
);

   `ETPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
   `ETPQ_ASSERT_NEXT(a_strobe_single, rsp_valid, !rsp_valid, "result strobe held two cycles")
   `ETPQ_ASSERT_NOW(a_empty_occ, rsp_valid && (rsp_data.status == etpq_pkg::ST_EMPTY), (rsp_data.occupancy == '0) && (rsp_data.out_key == '0), "empty pop with data or occupancy")
   `ETPQ_ASSERT_NOW(a_full_occ, rsp_valid && (rsp_data.status == etpq_pkg::ST_FULL), rsp_data.occupancy == etpq_pkg::OCC_BITS'(DEPTH), "full drop with wrong occupancy")
   `ETPQ_ASSERT_NOW(a_rsp_idle, rsp_valid, !busy, "result shown while still busy")

endmodule

bind event_time_priority_queue etpq_checker #(
   .DEPTH (DEPTH)
) u_etpq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
